### hdl/phr_pkg.sv
// Shared types and constants for the palette hue replacement pipeline.
`default_nettype none

package phr_pkg;

    // Palette ranges that are recoloured.
    localparam logic [7:0] SUIT_FIRST  = 8'd192;
    localparam logic [7:0] SUIT_LAST   = 8'd223;
    localparam logic [7:0] PLATE_FIRST = 8'd160;
    localparam logic [7:0] PLATE_LAST  = 8'd191;

    // Hue codes of 120, 240 and 360 degrees, and the last code of sectors 0, 2 and 4.
    localparam logic [7:0] HUE_120     = 8'd85;
    localparam logic [7:0] HUE_240     = 8'd170;
    localparam logic [7:0] HUE_360     = 8'd255;
    localparam logic [7:0] SECTOR0_END = 8'd42;
    localparam logic [7:0] SECTOR2_END = 8'd127;
    localparam logic [7:0] SECTOR4_END = 8'd212;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_SUIT_HUE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_PLATE_HUE = 1'b1;

    typedef enum logic [2:0] {
        SEC_RED_TO_YELLOW   = 3'd0,
        SEC_YELLOW_TO_GREEN = 3'd1,
        SEC_GREEN_TO_CYAN   = 3'd2,
        SEC_CYAN_TO_BLUE    = 3'd3,
        SEC_BLUE_TO_MAGENTA = 3'd4,
        SEC_MAGENTA_TO_RED  = 3'd5
    } t_sector;

    // Per-entry information that travels alongside the ratio division.
    typedef struct packed {
        logic       pass;
        t_sector    sector;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] span;
    } t_item;

    // Partial remainder and divisor of the ratio division.
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] den;
    } t_div;

endpackage

`default_nettype wire

### hdl/palette_hue_replace.sv
// Top level of the palette hue replacement pipeline.
// Stages in order: the front stage, the division steps, the product stage and the output register.
// Throughput: one beat per cycle; each stage holds its beat only while the stage after it is full.
// The depth is set by the ratio division, which resolves one quotient bit per stage.
// Reset clears every valid bit and loads the hue registers with 30 (suit) and 6 (plate).
`default_nettype none

module palette_hue_replace #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [phr_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire [7:0]                      i_cfg_wdata,
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    // entry_index [7:0], in_red [15:8], in_green [23:16], in_blue [31:24]
    input  wire [31:0]                     i_s_tdata,
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    // out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic [23:0]                    o_m_tdata
);
    import phr_pkg::*;

    localparam int unsigned QW = FRACTION_BITS;

    logic [7:0]    r_suit_hue;
    logic [7:0]    r_plate_hue;
    logic          en    [QW+2];
    logic          valid [QW+1];
    t_item         item  [QW+1];
    t_div          dv    [QW+1];
    logic [QW-1:0] q     [QW+1];
    logic [7:0]    out_red;
    logic [7:0]    out_green;
    logic [7:0]    out_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_suit_hue  <= 8'd30;
            r_plate_hue <= 8'd6;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SUIT_HUE:  r_suit_hue  <= i_cfg_wdata;
                REG_PLATE_HUE: r_plate_hue <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    phr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_down_en   (en[1]),
        .o_en        (en[0]),
        .i_index     (i_s_tdata[7:0]),
        .i_red       (i_s_tdata[15:8]),
        .i_green     (i_s_tdata[23:16]),
        .i_blue      (i_s_tdata[31:24]),
        .i_suit_hue  (r_suit_hue),
        .i_plate_hue (r_plate_hue),
        .o_valid     (valid[0]),
        .o_item      (item[0]),
        .o_div       (dv[0])
    );

    assign q[0] = '0;

    for (genvar j = 0; j < QW; j++) begin : g_div
        phr_div_step #(.QW(QW)) u_step (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (valid[j]),
            .i_down_en (en[j+2]),
            .o_en      (en[j+1]),
            .i_item    (item[j]),
            .i_div     (dv[j]),
            .i_q       (q[j]),
            .o_valid   (valid[j+1]),
            .o_item    (item[j+1]),
            .o_div     (dv[j+1]),
            .o_q       (q[j+1])
        );
    end

    phr_back #(.QW(QW)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (valid[QW]),
        .o_en    (en[QW+1]),
        .i_item  (item[QW]),
        .i_q     (q[QW]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_red   (out_red),
        .o_green (out_green),
        .o_blue  (out_blue)
    );

    assign o_s_tready = en[0];
    assign o_m_tdata  = {out_blue, out_green, out_red};

    // The pipeline refuses input only when every stage is full behind a stalled output.
    a_ready_only_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input refused while output is not stalled");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_suit_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_addr == REG_SUIT_HUE) |=> r_suit_hue == $past(i_cfg_wdata))
        else $error("suit hue write lost");

    a_plate_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_addr == REG_PLATE_HUE) |=> r_plate_hue == $past(i_cfg_wdata))
        else $error("plate hue write lost");

endmodule

`default_nettype wire

### hdl/phr_front.sv
// First pipeline stage: range selection, channel extremes, hue sector and ratio operands.
`default_nettype none

module phr_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  wire             i_down_en,
    output logic            o_en,
    input  wire [7:0]       i_index,
    input  wire [7:0]       i_red,
    input  wire [7:0]       i_green,
    input  wire [7:0]       i_blue,
    input  wire [7:0]       i_suit_hue,
    input  wire [7:0]       i_plate_hue,
    output logic            o_valid,
    output phr_pkg::t_item  o_item,
    output phr_pkg::t_div   o_div
);
    import phr_pkg::*;

    logic       r_valid;
    t_item      r_item;
    t_div       r_div;
    t_item      n_item;
    t_div       n_div;
    logic       in_suit;
    logic       in_plate;
    logic [7:0] hue;
    logic [7:0] hi_rg;
    logic [7:0] lo_rg;

    assign o_en = !r_valid || i_down_en;

    always_comb begin
        in_suit  = (i_index >= SUIT_FIRST) && (i_index <= SUIT_LAST);
        in_plate = (i_index >= PLATE_FIRST) && (i_index <= PLATE_LAST);
        hue      = in_suit ? i_suit_hue : i_plate_hue;
        hi_rg    = (i_red > i_green) ? i_red : i_green;
        lo_rg    = (i_red < i_green) ? i_red : i_green;

        n_item.pass  = !(in_suit || in_plate);
        n_item.red   = i_red;
        n_item.green = i_green;
        n_item.blue  = i_blue;
        n_item.hi    = (i_blue > hi_rg) ? i_blue : hi_rg;
        n_item.lo    = (i_blue < lo_rg) ? i_blue : lo_rg;
        n_item.span  = n_item.hi - n_item.lo;

        if (hue <= SECTOR0_END) begin
            n_item.sector = SEC_RED_TO_YELLOW;
            n_div.rem     = hue;
            n_div.den     = HUE_120 - hue;
        end else if (hue <= HUE_120) begin
            n_item.sector = SEC_YELLOW_TO_GREEN;
            n_div.rem     = HUE_120 - hue;
            n_div.den     = hue;
        end else if (hue <= SECTOR2_END) begin
            n_item.sector = SEC_GREEN_TO_CYAN;
            n_div.rem     = hue - HUE_120;
            n_div.den     = HUE_240 - hue;
        end else if (hue <= HUE_240) begin
            n_item.sector = SEC_CYAN_TO_BLUE;
            n_div.rem     = HUE_240 - hue;
            n_div.den     = hue - HUE_120;
        end else if (hue <= SECTOR4_END) begin
            n_item.sector = SEC_BLUE_TO_MAGENTA;
            n_div.rem     = hue - HUE_240;
            n_div.den     = HUE_360 - hue;
        end else begin
            n_item.sector = SEC_MAGENTA_TO_RED;
            n_div.rem     = HUE_360 - hue;
            n_div.den     = hue - HUE_240;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_item <= n_item;
            r_div  <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_div   = r_div;

endmodule

`default_nettype wire

### hdl/phr_div_step.sv
// One restoring division step of the hue ratio, producing one quotient bit per stage.
`default_nettype none

module phr_div_step #(
    parameter int unsigned QW = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  wire             i_down_en,
    output logic            o_en,
    input  phr_pkg::t_item  i_item,
    input  phr_pkg::t_div   i_div,
    input  wire [QW-1:0]    i_q,
    output logic            o_valid,
    output phr_pkg::t_item  o_item,
    output phr_pkg::t_div   o_div,
    output logic [QW-1:0]   o_q
);
    import phr_pkg::*;

    logic          r_valid;
    t_item         r_item;
    t_div          r_div;
    logic [QW-1:0] r_q;
    logic [8:0]    rem2;
    logic [8:0]    diff;
    logic          ge;
    t_div          n_div;

    assign o_en = !r_valid || i_down_en;

    always_comb begin
        rem2      = {i_div.rem, 1'b0};
        diff      = rem2 - {1'b0, i_div.den};
        ge        = rem2 >= {1'b0, i_div.den};
        n_div.den = i_div.den;
        n_div.rem = ge ? diff[7:0] : rem2[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_item <= i_item;
            r_div  <= n_div;
            r_q    <= {i_q[QW-2:0], ge};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_div   = r_div;
    assign o_q     = r_q;

endmodule

`default_nettype wire

### hdl/phr_back.sv
// Last two stages: ratio times span, then channel placement into the output register.
`default_nettype none

module phr_back #(
    parameter int unsigned QW = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_en,
    input  phr_pkg::t_item  i_item,
    input  wire [QW-1:0]    i_q,
    output logic            o_valid,
    input  wire             i_ready,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue
);
    import phr_pkg::*;

    logic            r_m_valid;
    t_item           r_m_item;
    logic [QW+7:0]   r_m_prod;
    logic            en_o;
    logic            r_o_valid;
    logic [7:0]      r_red;
    logic [7:0]      r_green;
    logic [7:0]      r_blue;
    logic [7:0]      n_red;
    logic [7:0]      n_green;
    logic [7:0]      n_blue;
    logic [7:0]      third;

    assign en_o = !r_o_valid || i_ready;
    assign o_en = !r_m_valid || en_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_en) begin
                r_m_valid <= i_valid;
            end
            if (en_o) begin
                r_o_valid <= r_m_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_m_item <= i_item;
            r_m_prod <= i_q * {{QW{1'b0}}, i_item.span};
        end
    end

    always_comb begin
        third = r_m_item.lo + r_m_prod[QW+7:QW];
        case (r_m_item.sector)
            SEC_RED_TO_YELLOW: begin
                n_red = r_m_item.hi; n_green = third; n_blue = r_m_item.lo;
            end
            SEC_YELLOW_TO_GREEN: begin
                n_red = third; n_green = r_m_item.hi; n_blue = r_m_item.lo;
            end
            SEC_GREEN_TO_CYAN: begin
                n_red = r_m_item.lo; n_green = r_m_item.hi; n_blue = third;
            end
            SEC_CYAN_TO_BLUE: begin
                n_red = r_m_item.lo; n_green = third; n_blue = r_m_item.hi;
            end
            SEC_BLUE_TO_MAGENTA: begin
                n_red = third; n_green = r_m_item.lo; n_blue = r_m_item.hi;
            end
            SEC_MAGENTA_TO_RED: begin
                n_red = r_m_item.hi; n_green = r_m_item.lo; n_blue = third;
            end
            default: begin
                n_red = r_m_item.red; n_green = r_m_item.green; n_blue = r_m_item.blue;
            end
        endcase
        if (r_m_item.pass) begin
            n_red   = r_m_item.red;
            n_green = r_m_item.green;
            n_blue  = r_m_item.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_o_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire
